FILE: hw/rtl/afd_pkg.sv
// Package for the API frame deframer: result type, phase codes and result kinds.
// No dependencies; imported by every module of the block.
`default_nettype none

package afd_pkg;

    localparam logic [7:0] START_DELIM = 8'h7E;
    localparam logic [7:0] SUM_TARGET  = 8'hFF;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_GOOD   = 2'd1;
    localparam logic [1:0] KIND_BAD    = 2'd2;
    localparam logic [1:0] KIND_LENERR = 2'd3;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_LEN_HI = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_TYPE   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_CSUM   = 3'd5;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CSUM_EN = 1'd1;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  frame_type;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [15:0] frame_data_length;
        logic        end_of_frame;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/api_frame_deframer_top.sv
// Top level of the API frame deframer: configuration registers, parser, result register.
// Depends on afd_pkg, afd_parser and afd_out_reg.
//
//   Channel  | Handshake                     | Payload
//   ---------+-------------------------------+------------------------------------------
//   input    | i_in_valid / o_in_stall       | i_rx_byte
//   output   | o_out_valid / i_out_stall     | o_result_kind .. o_end_of_frame
//   config   | i_cfg_we                      | i_cfg_index, i_cfg_data
//
// One byte is accepted in every unstalled cycle; any result appears in the next cycle.
// The single result register sets the rate: a byte waits only while a held item is stalled.
// Reset is synchronous and active low; it returns the parser to hunting for the delimiter.
// o_in_stall follows i_out_stall in the same cycle whenever a result is held.
`default_nettype none

module api_frame_deframer_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [7:0]                  i_rx_byte,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [1:0]                       o_result_kind,
    output logic [7:0]                       o_frame_type,
    output logic [7:0]                       o_data_byte,
    output logic [15:0]                      o_byte_index,
    output logic [15:0]                      o_frame_data_length,
    output logic                             o_end_of_frame,
    input  wire logic                        i_cfg_we,
    input  wire logic [afd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                 i_cfg_data
);
    import afd_pkg::*;

    logic [15:0] r_max_len;
    logic        r_csum_en;
    logic        accept;
    logic        full;
    logic        res_valid;
    t_result     res;
    t_result     out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= 16'd65534;
            r_csum_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_LEN: r_max_len <= i_cfg_data;
                CFG_CSUM_EN: r_csum_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = full;
    assign accept     = i_in_valid & ~full;

    afd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_max_len   (r_max_len),
        .i_csum_en   (r_csum_en),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    afd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_full      (full),
        .o_valid     (o_out_valid),
        .o_res       (out_res)
    );

    assign o_result_kind       = out_res.result_kind;
    assign o_frame_type        = out_res.frame_type;
    assign o_data_byte         = out_res.data_byte;
    assign o_byte_index        = out_res.byte_index;
    assign o_frame_data_length = out_res.frame_data_length;
    assign o_end_of_frame      = out_res.end_of_frame;

endmodule

`default_nettype wire

FILE: hw/rtl/afd_parser.sv
// Frame parser: phase register, length, type, count and checksum state.
// Depends on afd_pkg; produces at most one result for each accepted byte.
`default_nettype none

module afd_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_rx_byte,
    input  wire logic [15:0]     i_max_len,
    input  wire logic            i_csum_en,
    output logic                 o_res_valid,
    output afd_pkg::t_result     o_res
);
    import afd_pkg::*;

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_sum, n_sum;

    logic [15:0] dlen;
    logic [15:0] len_full;
    logic [15:0] len_m1;
    logic [15:0] count_inc;
    logic [7:0]  total;

    always_comb begin
        dlen      = r_len - 16'd1;
        len_full  = {r_len[15:8], i_rx_byte};
        len_m1    = len_full - 16'd1;
        count_inc = r_count + 16'd1;
        total     = r_sum + i_rx_byte;

        n_phase = r_phase;
        n_len   = r_len;
        n_type  = r_type;
        n_count = r_count;
        n_sum   = r_sum;

        o_res_valid = 1'b0;
        o_res       = '{result_kind: KIND_DATA, frame_type: 8'd0, data_byte: 8'd0,
                        byte_index: 16'd0, frame_data_length: 16'd0, end_of_frame: 1'b0};

        unique case (r_phase)
            PH_LEN_HI: begin
                n_len   = {i_rx_byte, 8'h00};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len = len_full;
                if (len_full == 16'd0) begin
                    n_phase                = PH_HUNT;
                    o_res_valid            = 1'b1;
                    o_res.result_kind      = KIND_LENERR;
                    o_res.end_of_frame     = 1'b1;
                end else if (len_m1 > i_max_len) begin
                    n_phase                 = PH_HUNT;
                    o_res_valid             = 1'b1;
                    o_res.result_kind       = KIND_LENERR;
                    o_res.frame_data_length = len_m1;
                    o_res.end_of_frame      = 1'b1;
                end else begin
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_type  = i_rx_byte;
                n_sum   = i_rx_byte;
                n_count = 16'd0;
                n_phase = (dlen == 16'd0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA: begin
                o_res_valid             = 1'b1;
                o_res.result_kind       = KIND_DATA;
                o_res.frame_type        = r_type;
                o_res.data_byte         = i_rx_byte;
                o_res.byte_index        = r_count;
                o_res.frame_data_length = dlen;
                n_sum   = total;
                n_count = count_inc;
                if (count_inc >= dlen) begin
                    n_phase = PH_CSUM;
                end
            end
            PH_CSUM: begin
                o_res_valid             = 1'b1;
                o_res.result_kind       = (!i_csum_en || total == SUM_TARGET) ?
                                          KIND_GOOD : KIND_BAD;
                o_res.frame_type        = r_type;
                o_res.data_byte         = i_rx_byte;
                o_res.frame_data_length = dlen;
                o_res.end_of_frame      = 1'b1;
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = (i_rx_byte == START_DELIM) ? PH_LEN_HI : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= 16'd0;
            r_type  <= 8'd0;
            r_count <= 16'd0;
            r_sum   <= 8'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_type  <= n_type;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/afd_out_reg.sv
// Result register between the parser and the output channel.
// Depends on afd_pkg; loads a new item in the cycle the held one is taken.
`default_nettype none

module afd_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire logic             i_res_valid,
    input  wire afd_pkg::t_result i_res,
    input  wire logic             i_out_stall,
    output logic                  o_full,
    output logic                  o_valid,
    output afd_pkg::t_result      o_res
);
    import afd_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    always_comb begin
        if (i_load) begin
            n_valid = i_res_valid;
        end else begin
            n_valid = r_valid & i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_full  = r_valid & i_out_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

FILE: tb/tb_api_frame_deframer_top.sv
// Self-checking testbench for api_frame_deframer_top: a directed table, then random frames.
// Depends on afd_pkg and the deframer RTL; results are checked against a built-in predictor.
`timescale 1ns / 1ps

module tb_api_frame_deframer_top;
    import afd_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RAND_ITEMS   = 1300;
    localparam int N_PHASES     = 7;
    localparam int PRINT_CAP    = 200;

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [15:0] value;
        logic        en;
        bit          fixed;
        t_result     res;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [7:0]           i_rx_byte;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_result_kind;
    logic [7:0]           o_frame_type;
    logic [7:0]           o_data_byte;
    logic [15:0]          o_byte_index;
    logic [15:0]          o_frame_data_length;
    logic                 o_end_of_frame;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    // Predictor state and its copy of the registers.
    logic [2:0]  pr_phase;
    logic [15:0] pr_len;
    logic [7:0]  pr_type;
    logic [15:0] pr_count;
    logic [7:0]  pr_sum;
    logic [15:0] pr_max_len;
    logic        pr_chk_en;

    t_result   pending_results[$];
    t_stim_row dir_rows[$];

    int  n_errors;
    int  n_results;
    int  n_items;
    int  n_counted;
    int  n_frames;
    int  n_cfg_writes;
    int  kind_seen[4];
    bit  calm;
    int  hold_left = 0;
    bit  hold_stall = 1'b0;

    api_frame_deframer_top u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_rx_byte           (i_rx_byte),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_result_kind       (o_result_kind),
        .o_frame_type        (o_frame_type),
        .o_data_byte         (o_data_byte),
        .o_byte_index        (o_byte_index),
        .o_frame_data_length (o_frame_data_length),
        .o_end_of_frame      (o_end_of_frame),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= PRINT_CAP) begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                      n_results, name, got, want));
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b, output bit has, output t_result r);
        logic [15:0] dl;
        logic [7:0]  total;
        has = 1'b0;
        r   = '0;
        dl  = pr_len - 16'd1;
        case (pr_phase)
            PH_LEN_HI: begin
                pr_len   = {b, 8'h00};
                pr_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                pr_len = {pr_len[15:8], b};
                dl     = pr_len - 16'd1;
                if (pr_len == 16'd0) begin
                    pr_phase       = PH_HUNT;
                    has            = 1'b1;
                    r.result_kind  = KIND_LENERR;
                    r.end_of_frame = 1'b1;
                end else if (dl > pr_max_len) begin
                    pr_phase            = PH_HUNT;
                    has                 = 1'b1;
                    r.result_kind       = KIND_LENERR;
                    r.frame_data_length = dl;
                    r.end_of_frame      = 1'b1;
                end else begin
                    pr_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                pr_type  = b;
                pr_sum   = b;
                pr_count = 16'd0;
                pr_phase = (dl == 16'd0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA: begin
                has                 = 1'b1;
                r.result_kind       = KIND_DATA;
                r.frame_type        = pr_type;
                r.data_byte         = b;
                r.byte_index        = pr_count;
                r.frame_data_length = dl;
                pr_sum              = pr_sum + b;
                pr_count            = pr_count + 16'd1;
                if (pr_count >= dl) begin
                    pr_phase = PH_CSUM;
                end
            end
            PH_CSUM: begin
                total               = pr_sum + b;
                has                 = 1'b1;
                r.result_kind       = (!pr_chk_en || total == SUM_TARGET) ?
                                      KIND_GOOD : KIND_BAD;
                r.frame_type        = pr_type;
                r.data_byte         = b;
                r.frame_data_length = dl;
                r.end_of_frame      = 1'b1;
                pr_phase            = PH_HUNT;
            end
            default: begin
                pr_phase = (b == START_DELIM) ? PH_LEN_HI : PH_HUNT;
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input bit fixed, input t_result fixed_res);
        int      gap;
        bit      has;
        t_result r;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        n_items++;
        if (pr_phase != PH_HUNT || b == START_DELIM) begin
            n_counted++;
        end
        deframe_byte(b, has, r);
        if (fixed) begin
            pending_results.push_back(fixed_res);
        end else if (has) begin
            pending_results.push_back(r);
        end
    endtask

    task automatic send_plain(input logic [7:0] b);
        send_byte(b, 1'b0, '0);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_set(input logic [15:0] max_len, input logic chk_en);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MAX_LEN;
        i_cfg_data  <= max_len;
        @(posedge i_clk);
        pr_max_len   = max_len;
        i_cfg_index <= CFG_CSUM_EN;
        i_cfg_data  <= {15'd0, chk_en};
        @(posedge i_clk);
        pr_chk_en  = chk_en;
        i_cfg_we  <= 1'b0;
        n_cfg_writes += 2;
    endtask

    task automatic send_frame();
        int          r;
        int          dl;
        logic [15:0] lw;
        logic [7:0]  ft;
        logic [7:0]  sum;
        logic [7:0]  bb;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            // Stray bytes between frames never include the delimiter.
            repeat ($urandom_range(1, 4)) begin
                bb = 8'($urandom_range(0, 255));
                if (bb == START_DELIM) begin
                    bb = ~bb;
                end
                send_plain(bb);
            end
        end else if (r < 16) begin
            if (pr_max_len >= 16'hFFFE || $urandom_range(0, 2) == 0) begin
                lw = 16'd0;
            end else begin
                lw = 16'($urandom_range(65535, int'(pr_max_len) + 2));
            end
            send_plain(START_DELIM);
            send_plain(lw[15:8]);
            send_plain(lw[7:0]);
        end else begin
            r  = $urandom_range(0, 99);
            dl = (r < 70) ? $urandom_range(0, 8) :
                 (r < 96) ? $urandom_range(9, 40) : $urandom_range(41, 300);
            if (dl > int'(pr_max_len)) begin
                dl = int'(pr_max_len);
            end
            lw  = 16'(dl + 1);
            ft  = 8'($urandom_range(0, 255));
            sum = ft;
            send_plain(START_DELIM);
            send_plain(lw[15:8]);
            send_plain(lw[7:0]);
            send_plain(ft);
            for (int i = 0; i < dl; i++) begin
                bb  = ($urandom_range(0, 9) == 0) ? START_DELIM : 8'($urandom_range(0, 255));
                sum = sum + bb;
                send_plain(bb);
            end
            bb = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : SUM_TARGET - sum;
            send_plain(bb);
            n_frames++;
        end
    endtask

    function automatic t_stim_row byte_row(input logic [7:0] b);
        t_stim_row s;
        s.kind  = ROW_BYTE;
        s.value = {8'h00, b};
        s.en    = 1'b0;
        s.fixed = 1'b0;
        s.res   = '0;
        return s;
    endfunction

    function automatic t_stim_row chk_row(input logic [7:0] b, input logic [1:0] kind,
                                          input logic [7:0] ft, input logic [7:0] db,
                                          input logic [15:0] dlen);
        t_stim_row s;
        s                         = byte_row(b);
        s.fixed                   = 1'b1;
        s.res.result_kind         = kind;
        s.res.frame_type          = ft;
        s.res.data_byte           = db;
        s.res.byte_index          = 16'd0;
        s.res.frame_data_length   = dlen;
        s.res.end_of_frame        = 1'b1;
        return s;
    endfunction

    function automatic t_stim_row cfg_row(input logic [15:0] max_len, input logic chk_en);
        t_stim_row s;
        s       = byte_row(8'h00);
        s.kind  = ROW_CFG;
        s.value = max_len;
        s.en    = chk_en;
        return s;
    endfunction

    always @(posedge i_clk) begin
        if (hold_left == 0) begin
            if (!calm && !hold_stall) begin
                hold_stall = 1'b1;
                hold_left  = pick_gap() + 1;
            end else begin
                hold_stall = 1'b0;
                hold_left  = $urandom_range(1, 12);
            end
        end
        hold_left--;
        i_out_stall <= hold_stall && !calm;
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            got.result_kind       = o_result_kind;
            got.frame_type        = o_frame_type;
            got.data_byte         = o_data_byte;
            got.byte_index        = o_byte_index;
            got.frame_data_length = o_frame_data_length;
            got.end_of_frame      = o_end_of_frame;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          n_results));
            end else begin
                want = pending_results.pop_front();
                kind_seen[got.result_kind]++;
                check_field("result_kind", 16'(got.result_kind), 16'(want.result_kind));
                check_field("frame_type", 16'(got.frame_type), 16'(want.frame_type));
                check_field("data_byte", 16'(got.data_byte), 16'(want.data_byte));
                check_field("byte_index", got.byte_index, want.byte_index);
                check_field("frame_data_length", got.frame_data_length,
                            want.frame_data_length);
                check_field("end_of_frame", 16'(got.end_of_frame),
                            16'(want.end_of_frame));
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Run stopped after %0d cycles with %0d results outstanding.",
                 CYCLE_LIMIT, pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [15:0] ph_max [N_PHASES];
        bit          ph_chk [N_PHASES];
        bit          ph_calm [N_PHASES];
        int          start;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_rx_byte   = 8'h00;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_MAX_LEN;
        i_cfg_data  = 16'd0;
        calm        = 1'b0;
        pr_phase    = PH_HUNT;
        pr_len      = 16'd0;
        pr_type     = 8'd0;
        pr_count    = 16'd0;
        pr_sum      = 8'd0;
        pr_max_len  = 16'd65534;
        pr_chk_en   = 1'b1;

        dir_rows.push_back(byte_row(8'h00));
        dir_rows.push_back(byte_row(8'hFF));
        dir_rows.push_back(byte_row(START_DELIM));
        dir_rows.push_back(byte_row(8'h00));
        dir_rows.push_back(chk_row(8'h00, KIND_LENERR, 8'h00, 8'h00, 16'd0));
        dir_rows.push_back(byte_row(START_DELIM));
        dir_rows.push_back(byte_row(8'h00));
        dir_rows.push_back(byte_row(8'h03));
        dir_rows.push_back(byte_row(8'h90));
        dir_rows.push_back(byte_row(START_DELIM));
        dir_rows.push_back(byte_row(8'hFF));
        dir_rows.push_back(chk_row(8'hF2, KIND_GOOD, 8'h90, 8'hF2, 16'd2));
        dir_rows.push_back(byte_row(START_DELIM));
        dir_rows.push_back(byte_row(8'h00));
        dir_rows.push_back(byte_row(8'h01));
        dir_rows.push_back(byte_row(8'h00));
        dir_rows.push_back(chk_row(8'h00, KIND_BAD, 8'h00, 8'h00, 16'd0));
        dir_rows.push_back(cfg_row(16'd0, 1'b0));
        dir_rows.push_back(byte_row(START_DELIM));
        dir_rows.push_back(byte_row(8'h00));
        dir_rows.push_back(chk_row(8'h02, KIND_LENERR, 8'h00, 8'h00, 16'd1));
        dir_rows.push_back(byte_row(START_DELIM));
        dir_rows.push_back(byte_row(8'h00));
        dir_rows.push_back(byte_row(8'h01));
        dir_rows.push_back(byte_row(8'h12));
        dir_rows.push_back(chk_row(8'h34, KIND_GOOD, 8'h12, 8'h34, 16'd0));
        dir_rows.push_back(cfg_row(16'd65533, 1'b1));
        dir_rows.push_back(byte_row(START_DELIM));
        dir_rows.push_back(byte_row(8'hFF));
        dir_rows.push_back(chk_row(8'hFF, KIND_LENERR, 8'h00, 8'h00, 16'hFFFE));

        ph_max  = '{16'd65534, 16'd1, 16'd0, 16'd24, 16'd65535, 16'd0, 16'h8000};
        ph_chk  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        ph_calm = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
        ph_max[5] = 16'($urandom_range(2, 400));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                wait_idle();
                cfg_set(dir_rows[k].value, dir_rows[k].en);
            end else begin
                send_byte(dir_rows[k].value[7:0], dir_rows[k].fixed, dir_rows[k].res);
            end
        end

        // Each phase starts from an idle block with a fresh pair of register values.
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            calm = ph_calm[p];
            cfg_set(ph_max[p], ph_chk[p]);
            start = n_counted;
            while (n_counted - start < RAND_ITEMS / N_PHASES) begin
                send_frame();
            end
            calm = 1'b0;
        end
        wait_idle();

        $display("Sent %0d items (%0d random frames) with %0d register writes.",
                 n_items, n_frames, n_cfg_writes);
        $display("Results: %0d data, %0d good, %0d checksum bad, %0d length errors.",
                 kind_seen[KIND_DATA], kind_seen[KIND_GOOD], kind_seen[KIND_BAD],
                 kind_seen[KIND_LENERR]);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
